// ===== rtl/olaps_pkg.sv =====
// shared constants and types for the overlap-add pitch shifter
`default_nettype none

package olaps_pkg;

  localparam int STORE_DEPTH = 65536;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;

  localparam int ADDR_BITS = $clog2(STORE_DEPTH);
  localparam int STEP_BITS = FRAC_BITS + 2;
  localparam int WIN_BITS  = 17;
  localparam int FADE_BITS = 16;
  localparam int CFG_BITS  = (STEP_BITS > WIN_BITS) ? STEP_BITS : WIN_BITS;
  localparam int IDX_BITS  = 2;

  // read offset, integer part indexes the window
  localparam int OFS_BITS  = ADDR_BITS + FRAC_BITS;
  // divider width, holds a window length of STORE_DEPTH
  localparam int DIV_BITS  = ADDR_BITS + 1;
  localparam int THR_BITS  = DIV_BITS + 1;
  localparam int GAIN_BITS = FRAC_BITS + 1;
  localparam int ACC_BITS  = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int FRAME_BITS = 2 * SAMPLE_BITS;

  localparam logic [GAIN_BITS-1:0] ONE_Q = GAIN_BITS'(1) << FRAC_BITS;

  localparam logic [IDX_BITS-1:0] REG_STEP = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_WIN  = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_FADE = 2'd2;

  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(ONE_Q);
  localparam logic [WIN_BITS-1:0]  WIN_RESET  = 17'd4800;
  localparam logic [FADE_BITS-1:0] FADE_RESET = 16'd2400;

  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] rem_init;
    logic [DIV_BITS-1:0] dividend;
    logic [DIV_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quot;
    logic [DIV_BITS-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/olaps_if.sv =====
// stream interfaces for input frames and mixed output frames
`default_nettype none

interface olaps_in_if import olaps_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface olaps_out_if import olaps_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/ola_pitch_shifter.sv =====
// top level of the stereo overlap-add pitch shifter
//
// Each accepted stereo frame is written to a 65536-frame sample store and
// produces one crossfaded output frame. Each frame is worked through by one
// shared 17-step restoring divider that runs three to five times per frame
// (write index wrap, crossfade gain, two tap addresses, and the fade base on
// a window restart), plus one store read per tap and a seven-step mix on a
// single multiplier. Input ready is high only while the sequencer is idle;
// a finished frame sits in an output register so the next frame can start
// while it waits. After reset a clearing pass writes zeros to all 65536
// store entries, one per cycle, before the first input is taken;
// configuration writes are taken at any time but are only meant for idle.
`default_nettype none

module ola_pitch_shifter import olaps_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_wdata,
  olaps_in_if.sink                 din,
  olaps_out_if.source              dout
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_WMOD_GO, S_WMOD_WAIT,
    S_GAIN_GO, S_GAIN_WAIT,
    S_P0_GO, S_P0_WAIT, S_P0_RD, S_P0_LAT,
    S_P1_GO, S_P1_WAIT, S_P1_RD, S_P1_LAT,
    S_MIX, S_UPD,
    S_FB_GO, S_FB_WAIT,
    S_FINISH
  } state_t;

  localparam int Q_BITS = ACC_BITS - FRAC_BITS;
  localparam logic signed [Q_BITS-1:0] QMAX = Q_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Q_BITS-1:0] QMIN = ~QMAX;
  localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1 << (FRAC_BITS - 1));

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [ACC_BITS-1:0] a
  );
    logic signed [ACC_BITS-1:0] t;
    logic signed [Q_BITS-1:0]   q;
    t = a + RND_HALF;
    q = $signed(t[ACC_BITS-1:FRAC_BITS]);
    if (q > QMAX) begin
      q = QMAX;
    end else if (q < QMIN) begin
      q = QMIN;
    end
    return SAMPLE_BITS'(q);
  endfunction

  // configuration
  logic [STEP_BITS-1:0] step;
  logic [WIN_BITS-1:0]  win;
  logic [FADE_BITS-1:0] fade;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_RESET;
      win  <= WIN_RESET;
      fade <= FADE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP: step <= cfg_wdata[STEP_BITS-1:0];
        REG_WIN:  win  <= cfg_wdata[WIN_BITS-1:0];
        REG_FADE: fade <= cfg_wdata[FADE_BITS-1:0];
        default:  ;
      endcase
    end
  end

  // state
  state_t                       state;
  logic [ADDR_BITS-1:0]         clr_addr;
  logic [ADDR_BITS-1:0]         wr_idx;
  logic [OFS_BITS-1:0]          ofs;
  logic [ADDR_BITS-1:0]         base;
  logic [ADDR_BITS-1:0]         fbase;
  logic [ADDR_BITS-1:0]         rd_addr;
  logic [GAIN_BITS-1:0]         gain;
  logic [THR_BITS-1:0]          fb_x;
  logic [FRAME_BITS-1:0]        s0;
  logic [FRAME_BITS-1:0]        s1;
  logic [2:0]                   mstep;
  logic signed [ACC_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]   acc;
  logic signed [SAMPLE_BITS-1:0] res_l;
  logic signed [SAMPLE_BITS-1:0] res_r;
  logic signed [SAMPLE_BITS-1:0] out_l;
  logic signed [SAMPLE_BITS-1:0] out_r;
  logic                         out_valid;

  // derived values
  logic [DIV_BITS-1:0]  len;
  logic [THR_BITS-1:0]  thr;
  logic                 thr_pos;
  logic                 gain_full;
  logic [OFS_BITS:0]    ofs_sum;
  logic                 restart;
  logic [DIV_BITS-1:0]  fb_mag;
  logic [GAIN_BITS-1:0] gain_c;
  logic                 out_free;
  logic                 accept;

  always_comb begin
    if (win == '0) begin
      len = DIV_BITS'(1);
    end else if (32'(win) > STORE_DEPTH) begin
      len = DIV_BITS'(STORE_DEPTH);
    end else begin
      len = DIV_BITS'(win);
    end
    thr       = THR_BITS'(len) - THR_BITS'(1) - THR_BITS'(fade);
    thr_pos   = !thr[THR_BITS-1] && (thr != '0);
    gain_full = (fade == '0) || (ofs >= OFS_BITS'({fade, {FRAC_BITS{1'b0}}}));
    ofs_sum   = {1'b0, ofs} + (OFS_BITS + 1)'(step);
    restart   = !thr_pos ||
                (ofs_sum >= (OFS_BITS + 1)'({thr[ADDR_BITS-1:0], {FRAC_BITS{1'b0}}}));
    fb_mag    = fb_x[THR_BITS-1] ? DIV_BITS'(~fb_x + THR_BITS'(1)) : DIV_BITS'(fb_x);
    gain_c    = ONE_Q - gain;
    out_free  = !out_valid || dout.ready;
    accept    = din.valid && din.ready;
  end

  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    div_req = '0;
    div_req.divisor = len;
    case (state)
      S_WMOD_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_BITS'(wr_idx) + DIV_BITS'(1);
      end
      S_GAIN_GO: begin
        div_req.start    = !gain_full;
        div_req.rem_init = DIV_BITS'(ofs[OFS_BITS-1:DIV_BITS]);
        div_req.dividend = ofs[DIV_BITS-1:0];
        div_req.divisor  = DIV_BITS'(fade);
      end
      S_P0_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_BITS'(base) + DIV_BITS'(ofs[OFS_BITS-1:FRAC_BITS]);
      end
      S_P1_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_BITS'(fbase) + DIV_BITS'(ofs[OFS_BITS-1:FRAC_BITS]);
      end
      S_FB_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = fb_mag;
      end
      default: ;
    endcase
  end

  olaps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sample store
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [FRAME_BITS-1:0] ram_wdata;
  logic [FRAME_BITS-1:0] ram_rdata;

  always_comb begin
    ram_we    = (state == S_CLEAR) || accept;
    ram_waddr = (state == S_CLEAR) ? clr_addr : wr_idx;
    ram_wdata = (state == S_CLEAR) ? '0 : {din.left_in, din.right_in};
  end

  olaps_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // shared multiplier operands
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [GAIN_BITS:0]     mul_b;
  logic signed [ACC_BITS-1:0]    mul_p;

  always_comb begin
    case (mstep)
      3'd0:    mul_a = $signed(s0[FRAME_BITS-1:SAMPLE_BITS]);
      3'd1:    mul_a = $signed(s1[FRAME_BITS-1:SAMPLE_BITS]);
      3'd3:    mul_a = $signed(s0[SAMPLE_BITS-1:0]);
      3'd4:    mul_a = $signed(s1[SAMPLE_BITS-1:0]);
      default: mul_a = '0;
    endcase
    mul_b = ((mstep == 3'd0) || (mstep == 3'd3)) ? $signed({1'b0, gain})
                                                 : $signed({1'b0, gain_c});
    mul_p = mul_a * mul_b;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      wr_idx    <= '0;
      ofs       <= '0;
      base      <= '0;
      fbase     <= '0;
      mstep     <= '0;
      out_valid <= 1'b0;
    end else begin
      prod <= mul_p;
      // output register loads a finished frame or empties on a transfer
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
        out_l     <= res_l;
        out_r     <= res_r;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_BITS'(1);
          if (clr_addr == {ADDR_BITS{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_WMOD_GO;
          end
        end
        S_WMOD_GO: state <= S_WMOD_WAIT;
        S_WMOD_WAIT: begin
          if (div_rsp.done) begin
            wr_idx <= ADDR_BITS'(div_rsp.rem);
            state  <= S_GAIN_GO;
          end
        end
        S_GAIN_GO: begin
          if (gain_full) begin
            gain  <= ONE_Q;
            state <= S_P0_GO;
          end else begin
            state <= S_GAIN_WAIT;
          end
        end
        S_GAIN_WAIT: begin
          if (div_rsp.done) begin
            gain  <= div_rsp.quot[GAIN_BITS-1:0];
            state <= S_P0_GO;
          end
        end
        S_P0_GO: state <= S_P0_WAIT;
        S_P0_WAIT: begin
          if (div_rsp.done) begin
            rd_addr <= ADDR_BITS'(div_rsp.rem);
            state   <= S_P0_RD;
          end
        end
        S_P0_RD: state <= S_P0_LAT;
        S_P0_LAT: begin
          s0    <= ram_rdata;
          state <= S_P1_GO;
        end
        S_P1_GO: state <= S_P1_WAIT;
        S_P1_WAIT: begin
          if (div_rsp.done) begin
            rd_addr <= ADDR_BITS'(div_rsp.rem);
            state   <= S_P1_RD;
          end
        end
        S_P1_RD: state <= S_P1_LAT;
        S_P1_LAT: begin
          s1    <= ram_rdata;
          mstep <= '0;
          state <= S_MIX;
        end
        S_MIX: begin
          mstep <= mstep + 3'd1;
          case (mstep)
            3'd1, 3'd4: acc <= prod;
            3'd2, 3'd5: acc <= acc + prod;
            3'd3: res_l <= round_sat(acc);
            3'd6: begin
              res_r <= round_sat(acc);
              state <= S_UPD;
            end
            default: ;
          endcase
        end
        S_UPD: begin
          if (restart) begin
            ofs   <= '0;
            fb_x  <= THR_BITS'(base) + thr;
            base  <= wr_idx;
            state <= S_FB_GO;
          end else begin
            ofs   <= ofs_sum[OFS_BITS-1:0];
            state <= S_FINISH;
          end
        end
        S_FB_GO: state <= S_FB_WAIT;
        S_FB_WAIT: begin
          if (div_rsp.done) begin
            if (!fb_x[THR_BITS-1]) begin
              fbase <= ADDR_BITS'(div_rsp.rem);
            end else if (div_rsp.rem == '0) begin
              fbase <= '0;
            end else begin
              fbase <= ADDR_BITS'(len - div_rsp.rem);
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign din.ready      = (state == S_IDLE);
  assign dout.valid     = out_valid;
  assign dout.left_out  = out_l;
  assign dout.right_out = out_r;

  // checks
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_WMOD_WAIT || state == S_GAIN_WAIT ||
                      state == S_P0_WAIT || state == S_P1_WAIT || state == S_FB_WAIT))
    else $error("divider finished outside a wait state");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIX) |-> (gain <= ONE_Q))
    else $error("crossfade gain above one");

  a_wr_idx_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == S_WMOD_WAIT && div_rsp.done) |=> (DIV_BITS'(wr_idx) < len))
    else $error("write index not inside window");

  a_fbase_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == S_FB_WAIT && div_rsp.done) |=> (DIV_BITS'(fbase) < len))
    else $error("fade base not inside window");

endmodule

`default_nettype wire

// ===== rtl/olaps_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module olaps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/olaps_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module olaps_div import olaps_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);

  localparam int CNT_BITS = $clog2(DIV_BITS + 1);

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] cnt;
  logic [DIV_BITS-1:0] rem;
  logic [DIV_BITS-1:0] quo;
  logic [DIV_BITS-1:0] dvs;

  logic [DIV_BITS:0] shifted;
  logic [DIV_BITS:0] diff;
  logic              ge;

  always_comb begin
    shifted = {rem, quo[DIV_BITS-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIV_BITS);
        rem  <= req.rem_init;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
        quo <= {quo[DIV_BITS-2:0], ge};
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire
